// ----- hdl/pkv_pkg.sv -----
package pkv_pkg;

    localparam int MODE_W       = 2;
    localparam int SEQ_W        = 4;
    localparam int LAYER_W      = 7;
    localparam int POS_W        = 16;
    localparam int PAGE_ID_W    = 6;
    localparam int OFFSET_W     = 27;
    localparam int FREE_W       = 7;
    localparam int PT_W         = 9;
    localparam int RW_W         = 13;
    localparam int LEN_W        = 17;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 13;

    typedef logic [MODE_W-1:0] mode_t;

    localparam mode_t MODE_OPEN   = 2'd0;
    localparam mode_t MODE_CLOSE  = 2'd1;
    localparam mode_t MODE_APPEND = 2'd2;
    localparam mode_t MODE_LOOKUP = 2'd3;

    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    localparam cfg_idx_t CFG_PAGE_TOKENS = 2'd0;
    localparam cfg_idx_t CFG_ROW_WORDS   = 2'd1;

    localparam logic [PT_W-1:0] PT_RESET = 9'd16;
    localparam logic [RW_W-1:0] RW_RESET = 13'd128;

endpackage

// ----- hdl/pkv_ram.sv -----
module pkv_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ----- hdl/pkv_div.sv -----
module pkv_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [pkv_pkg::POS_W-1:0]   dividend,
    input  logic [pkv_pkg::PT_W-1:0]    divisor,
    output logic [pkv_pkg::POS_W-1:0]   quotient,
    output logic [pkv_pkg::PT_W-1:0]    remainder,
    output logic                        done
);

    import pkv_pkg::*;

    localparam int CNT_W = $clog2(POS_W);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(POS_W - 1);

    logic [POS_W-1:0] q_reg;
    logic [PT_W-1:0]  rem_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [PT_W:0]    r_sh;
    logic [PT_W:0]    diff;
    logic             ge;

    // One quotient bit per cycle, restoring form.
    always_comb
    begin
        r_sh = {rem_reg, q_reg[POS_W-1]};
        diff = r_sh - {1'b0, divisor};
        ge   = r_sh >= {1'b0, divisor};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            q_reg    <= dividend;
            rem_reg  <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            q_reg   <= {q_reg[POS_W-2:0], ge};
            rem_reg <= ge ? diff[PT_W-1:0] : r_sh[PT_W-1:0];
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == LAST_STEP)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    assign quotient  = q_reg;
    assign remainder = rem_reg;
    assign done      = done_reg;

endmodule

// ----- hdl/paged_kv_block_table_top.sv -----
// Channel   Handshake            Beat contents
// cfg       cfg_valid/cfg_ready  cfg_index, cfg_data
// in        in_valid/in_stall    mode, seq_id, layer, pos
// out       out_valid/out_stall  status, page_id, row_offset, free_pages
//
// One item at a time: the bit-serial divider for pos / page_tokens (16 quotient steps),
// then the multiply states ST_MUL1 and ST_MUL2 for the row offset,
// then the request itself.
// Append passes through ST_AP_CHK, ST_AP_RD and ST_AP_WR for each page taken from the free
// stack; close passes through ST_CL_RD and ST_CL_WR for each page returned to it.
// No clearing pass after reset; the block takes a beat straight out of reset.
// A result waits in the output register while out_stall is high.
module paged_kv_block_table_top #(
    parameter int PAGE_COUNT = 64,
    parameter int MAX_SEQS   = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [pkv_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [pkv_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [pkv_pkg::MODE_W-1:0]      mode,
    input  logic [pkv_pkg::SEQ_W-1:0]       seq_id,
    input  logic [pkv_pkg::LAYER_W-1:0]     layer,
    input  logic [pkv_pkg::POS_W-1:0]       pos,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic                            status,
    output logic [pkv_pkg::PAGE_ID_W-1:0]   page_id,
    output logic [pkv_pkg::OFFSET_W-1:0]    row_offset,
    output logic [pkv_pkg::FREE_W-1:0]      free_pages
);

    import pkv_pkg::*;

    localparam int PW       = $clog2(PAGE_COUNT);
    localparam int CW       = $clog2(PAGE_COUNT + 1);
    localparam int SW       = (MAX_SEQS > 1) ? $clog2(MAX_SEQS) : 1;
    localparam int BT_DEPTH = MAX_SEQS << PW;
    localparam int SQ_W     = CW + LEN_W;
    localparam int P1_W     = LAYER_W + PT_W;
    localparam int P2_W     = P1_W + 1 + RW_W;
    localparam logic [CW-1:0] PAGES_C = CW'(PAGE_COUNT);

    typedef enum logic [3:0] {
        ST_IDLE, ST_DIV, ST_MUL1, ST_MUL2, ST_DECIDE, ST_CL_RD, ST_CL_WR,
        ST_AP_CHK, ST_AP_RD, ST_AP_WR, ST_BT_RD, ST_DONE
    } state_t;

    state_t state_reg;

    logic [PT_W-1:0]    page_tokens_reg;
    logic [RW_W-1:0]    row_words_reg;
    logic [PT_W-1:0]    pt_eff;

    mode_t              mode_reg;
    logic [SEQ_W-1:0]   seq_reg;
    logic [LAYER_W-1:0] layer_reg;
    logic [POS_W-1:0]   pos_reg;
    logic               seq_ok_reg;
    logic [SW-1:0]      sidx;

    logic [CW-1:0]      free_top_reg;
    logic [CW-1:0]      low_mark_reg;
    logic [MAX_SEQS-1:0] seq_open_reg;
    logic [CW-1:0]      cnt_reg;
    logic [LEN_W-1:0]   len_reg;

    logic [P1_W-1:0]    prod1_reg;
    logic [OFFSET_W-1:0] offset_reg;
    logic               hit_reg;

    logic               out_valid_reg;
    logic               status_reg;
    logic [PW-1:0]      page_reg;
    logic [OFFSET_W-1:0] row_offset_reg;
    logic [CW-1:0]      free_out_reg;

    logic               div_start;
    logic [POS_W-1:0]   quot;
    logic [PT_W-1:0]    rem;
    logic               div_done;

    logic               st_we;
    logic [PW-1:0]      st_rd_addr;
    logic [PW-1:0]      st_rd_data;
    logic [CW-1:0]      ft_m1;
    logic [PW-1:0]      popped;

    logic               bt_we;
    logic [SW+PW-1:0]   bt_wr_addr;
    logic [SW+PW-1:0]   bt_rd_addr;
    logic [PW-1:0]      bt_rd_data;

    logic               sq_we;
    logic [SQ_W-1:0]    sq_wr_data;
    logic [SQ_W-1:0]    sq_rd_data;
    logic [CW-1:0]      sq_cnt;
    logic [LEN_W-1:0]   sq_len;

    logic [LEN_W-1:0]   quot_ext;
    logic [LEN_W-1:0]   cnt_ext;
    logic [LEN_W-1:0]   pos_plus1;
    logic [P2_W-1:0]    prod2;
    logic               accept;
    logic [SW+SEQ_W-1:0] seq_wide;
    logic [PW+PAGE_ID_W-1:0] page_wide;
    logic [CW+FREE_W-1:0]    free_wide;

    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != ST_IDLE);
    assign cfg_ready = 1'b1;
    assign pt_eff   = (page_tokens_reg == '0) ? PT_W'(1) : page_tokens_reg;
    assign seq_wide = {{SW{1'b0}}, seq_reg};
    assign sidx     = seq_wide[SW-1:0];
    assign div_start = accept;

    assign sq_cnt   = sq_rd_data[SQ_W-1:LEN_W];
    assign sq_len   = sq_rd_data[LEN_W-1:0];
    assign quot_ext = LEN_W'(quot);
    assign cnt_ext  = LEN_W'(cnt_reg);
    assign pos_plus1 = LEN_W'(pos_reg) + 1'b1;
    assign prod2    = (P2_W'(prod1_reg) + P2_W'(rem)) * P2_W'(row_words_reg);

    // Stack entries below the lowest top ever reached were never written and are
    // read as their own index; everything at or above it was pushed.
    assign ft_m1      = free_top_reg - 1'b1;
    assign st_rd_addr = ft_m1[PW-1:0];
    assign popped     = (ft_m1 < low_mark_reg) ? ft_m1[PW-1:0] : st_rd_data;
    assign st_we      = (state_reg == ST_CL_WR);

    assign bt_we      = (state_reg == ST_AP_WR);
    assign bt_wr_addr = {sidx, cnt_reg[PW-1:0]};
    assign bt_rd_addr = (state_reg == ST_CL_RD) ? {sidx, cnt_reg[PW-1:0]}
                                                : {sidx, quot[PW-1:0]};

    always_comb
    begin
        sq_we      = 1'b0;
        sq_wr_data = {cnt_reg, len_reg};
        if (state_reg == ST_DECIDE && seq_ok_reg && mode_reg == MODE_OPEN
            && !seq_open_reg[sidx])
        begin
            sq_we      = 1'b1;
            sq_wr_data = '0;
        end
        else if (state_reg == ST_AP_CHK)
        begin
            if (quot_ext >= cnt_ext)
            begin
                sq_we = (cnt_reg == PAGES_C) || (free_top_reg == '0);
            end
            else
            begin
                sq_we      = 1'b1;
                sq_wr_data = {cnt_reg, pos_plus1};
            end
        end
    end

    pkv_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (pos),
        .divisor   (pt_eff),
        .quotient  (quot),
        .remainder (rem),
        .done      (div_done)
    );

    pkv_ram #(.WIDTH(PW), .DEPTH(PAGE_COUNT), .AW(PW)) u_free_stack (
        .clk     (clk),
        .we      (st_we),
        .wr_addr (free_top_reg[PW-1:0]),
        .wr_data (bt_rd_data),
        .rd_addr (st_rd_addr),
        .rd_data (st_rd_data)
    );

    pkv_ram #(.WIDTH(PW), .DEPTH(BT_DEPTH), .AW(SW + PW)) u_block_table (
        .clk     (clk),
        .we      (bt_we),
        .wr_addr (bt_wr_addr),
        .wr_data (popped),
        .rd_addr (bt_rd_addr),
        .rd_data (bt_rd_data)
    );

    pkv_ram #(.WIDTH(SQ_W), .DEPTH(MAX_SEQS), .AW(SW)) u_seq_info (
        .clk     (clk),
        .we      (sq_we),
        .wr_addr (sidx),
        .wr_data (sq_wr_data),
        .rd_addr (sidx),
        .rd_data (sq_rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            page_tokens_reg <= PT_RESET;
            row_words_reg   <= RW_RESET;
            free_top_reg    <= PAGES_C;
            low_mark_reg    <= PAGES_C;
            seq_open_reg    <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    CFG_PAGE_TOKENS: page_tokens_reg <= cfg_data[PT_W-1:0];
                    CFG_ROW_WORDS:   row_words_reg   <= cfg_data[RW_W-1:0];
                    default: ;
                endcase
            end

            // In ST_DONE the output register is reloaded below instead.
            if (out_valid_reg && !out_stall && state_reg != ST_DONE)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        mode_reg   <= mode;
                        seq_reg    <= seq_id;
                        layer_reg  <= layer;
                        pos_reg    <= pos;
                        seq_ok_reg <= (32'(seq_id) < MAX_SEQS);
                        hit_reg    <= 1'b0;
                        state_reg  <= ST_DIV;
                    end
                end
                ST_DIV:
                begin
                    if (div_done)
                    begin
                        state_reg <= ST_MUL1;
                    end
                end
                ST_MUL1:
                begin
                    prod1_reg <= P1_W'(layer_reg) * P1_W'(pt_eff);
                    state_reg <= ST_MUL2;
                end
                ST_MUL2:
                begin
                    offset_reg <= prod2[OFFSET_W-1:0];
                    state_reg  <= ST_DECIDE;
                end
                ST_DECIDE:
                begin
                    cnt_reg <= (mode_reg == MODE_CLOSE) ? '0 : sq_cnt;
                    len_reg <= sq_len;
                    if (!seq_ok_reg)
                    begin
                        state_reg <= ST_DONE;
                    end
                    else
                    begin
                        unique case (mode_reg)
                            MODE_OPEN:
                            begin
                                seq_open_reg[sidx] <= 1'b1;
                                state_reg          <= ST_DONE;
                            end
                            MODE_CLOSE:
                            begin
                                state_reg <= seq_open_reg[sidx] ? ST_CL_RD : ST_DONE;
                            end
                            MODE_APPEND:
                            begin
                                state_reg <= seq_open_reg[sidx] ? ST_AP_CHK : ST_DONE;
                            end
                            MODE_LOOKUP:
                            begin
                                if (seq_open_reg[sidx] && LEN_W'(pos_reg) < sq_len
                                    && quot_ext < LEN_W'(sq_cnt))
                                begin
                                    hit_reg   <= 1'b1;
                                    state_reg <= ST_BT_RD;
                                end
                                else
                                begin
                                    state_reg <= ST_DONE;
                                end
                            end
                            default: state_reg <= ST_DONE;
                        endcase
                    end
                end
                ST_CL_RD:
                begin
                    if (cnt_reg == sq_cnt)
                    begin
                        seq_open_reg[sidx] <= 1'b0;
                        state_reg          <= ST_DONE;
                    end
                    else
                    begin
                        state_reg <= ST_CL_WR;
                    end
                end
                ST_CL_WR:
                begin
                    free_top_reg <= free_top_reg + 1'b1;
                    cnt_reg      <= cnt_reg + 1'b1;
                    state_reg    <= ST_CL_RD;
                end
                ST_AP_CHK:
                begin
                    if (quot_ext >= cnt_ext)
                    begin
                        if ((cnt_reg == PAGES_C) || (free_top_reg == '0))
                        begin
                            state_reg <= ST_DONE;
                        end
                        else
                        begin
                            state_reg <= ST_AP_RD;
                        end
                    end
                    else
                    begin
                        hit_reg   <= 1'b1;
                        state_reg <= ST_BT_RD;
                    end
                end
                ST_AP_RD:
                begin
                    state_reg <= ST_AP_WR;
                end
                ST_AP_WR:
                begin
                    cnt_reg      <= cnt_reg + 1'b1;
                    free_top_reg <= ft_m1;
                    if (ft_m1 < low_mark_reg)
                    begin
                        low_mark_reg <= ft_m1;
                    end
                    state_reg <= ST_AP_CHK;
                end
                ST_BT_RD:
                begin
                    state_reg <= ST_DONE;
                end
                ST_DONE:
                begin
                    if (!out_valid_reg || !out_stall)
                    begin
                        out_valid_reg  <= 1'b1;
                        status_reg     <= !(hit_reg || (seq_ok_reg &&
                                          (mode_reg == MODE_OPEN ||
                                           mode_reg == MODE_CLOSE)));
                        page_reg       <= hit_reg ? bt_rd_data : '0;
                        row_offset_reg <= hit_reg ? offset_reg : '0;
                        free_out_reg   <= free_top_reg;
                        state_reg      <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign page_wide  = {{PAGE_ID_W{1'b0}}, page_reg};
    assign free_wide  = {{FREE_W{1'b0}}, free_out_reg};
    assign out_valid  = out_valid_reg;
    assign status     = status_reg;
    assign page_id    = page_wide[PAGE_ID_W-1:0];
    assign row_offset = row_offset_reg;
    assign free_pages = free_wide[FREE_W-1:0];

endmodule

// ----- hdl/pkv_checker.sv -----
module pkv_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            in_valid,
    input logic                            in_stall,
    input logic                            out_valid,
    input logic                            out_stall,
    input logic                            status,
    input logic [pkv_pkg::PAGE_ID_W-1:0]   page_id,
    input logic [pkv_pkg::OFFSET_W-1:0]    row_offset
);

    import pkv_pkg::*;

    // A result beat that is held back stays offered.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result beat dropped while stalled");

    // Every accepted request moves the block out of its idle state, so the input closes right after a beat.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input open in the cycle after an accepted beat");

    // An error result carries no page and no offset.
    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status |-> (page_id == '0) && (row_offset == '0))
        else $error("error result with page or offset set");

    // A new result only appears at the end of a request's work.
    a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result appeared without a request in progress");

endmodule

bind paged_kv_block_table_top pkv_checker u_pkv_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .status     (status),
    .page_id    (page_id),
    .row_offset (row_offset)
);
